FILE: rtl/core/gifx_pkg.sv
package gifx_pkg;

  localparam logic [7:0] LblGc   = 8'hF9;
  localparam logic [7:0] LblComm = 8'hFE;
  localparam logic [7:0] LblApp  = 8'hFF;

  localparam logic [7:0] GcSize   = 8'd4;
  localparam logic [7:0] AppSize  = 8'd11;
  localparam logic [7:0] AppIdLen = 8'd8;
  localparam logic [7:0] AppAuLen = 8'd3;

  localparam int unsigned OutDataW = 48;

  typedef enum logic [2:0] {
    KIND_GC_DONE  = 3'd0,
    KIND_COMMENT  = 3'd1,
    KIND_APP_ID   = 3'd2,
    KIND_EXT_END  = 3'd3,
    KIND_BAD_GC   = 3'd4,
    KIND_BAD_APP  = 3'd5,
    KIND_BAD_TERM = 3'd6
  } gifx_kind_e;

  typedef struct packed {
    logic        valid;
    gifx_kind_e  kind;
    logic [7:0]  data_byte;
    logic [2:0]  disposal;
    logic        user_wait;
    logic        transparent;
    logic [15:0] delay;
    logic [7:0]  trans_index;
    logic [7:0]  ext_label;
  } gifx_res_t;

endpackage

FILE: rtl/core/gifx_parse_fsm.sv
module gifx_parse_fsm
  import gifx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output gifx_res_t  res_o
);

  typedef enum logic [10:0] {
    PH_LABEL    = 11'b000_0000_0001,
    PH_GC_SIZE  = 11'b000_0000_0010,
    PH_GC_BODY  = 11'b000_0000_0100,
    PH_GC_TERM  = 11'b000_0000_1000,
    PH_CM_SIZE  = 11'b000_0001_0000,
    PH_CM_DATA  = 11'b000_0010_0000,
    PH_APP_SIZE = 11'b000_0100_0000,
    PH_APP_ID   = 11'b000_1000_0000,
    PH_APP_AUTH = 11'b001_0000_0000,
    PH_SK_SIZE  = 11'b010_0000_0000,
    PH_SK_DATA  = 11'b100_0000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  label_q, label_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] delay_q, delay_d;
  logic [7:0]  index_q, index_d;
  logic [7:0]  count_dec;

  assign count_dec = count_q - 8'd1;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    label_d = label_q;
    flags_d = flags_q;
    delay_d = delay_q;
    index_d = index_q;
    res_o                   = '0;
    res_o.ext_label         = label_q;

    case (phase_q)
      PH_LABEL: begin
        label_d = byte_i;
        if (byte_i == LblGc) begin
          phase_d = PH_GC_SIZE;
        end else if (byte_i == LblComm) begin
          phase_d = PH_CM_SIZE;
        end else if (byte_i == LblApp) begin
          phase_d = PH_APP_SIZE;
        end else begin
          phase_d = PH_SK_SIZE;
        end
      end
      PH_GC_SIZE: begin
        if (byte_i != GcSize) begin
          phase_d     = PH_LABEL;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_BAD_GC;
        end else begin
          count_d = GcSize;
          phase_d = PH_GC_BODY;
        end
      end
      PH_GC_BODY: begin
        if (count_q == 8'd4) begin
          flags_d = byte_i;
        end else if (count_q == 8'd3) begin
          delay_d = {delay_q[15:8], byte_i};
        end else if (count_q == 8'd2) begin
          delay_d = {byte_i, delay_q[7:0]};
        end else begin
          index_d = byte_i;
        end
        count_d = count_dec;
        if (count_dec == 8'd0) begin
          phase_d = PH_GC_TERM;
        end
      end
      PH_GC_TERM: begin
        phase_d           = PH_LABEL;
        res_o.valid       = 1'b1;
        res_o.kind        = (byte_i == 8'd0) ? KIND_GC_DONE : KIND_BAD_TERM;
        res_o.disposal    = flags_q[4:2];
        res_o.user_wait   = flags_q[1];
        res_o.transparent = flags_q[0];
        res_o.delay       = delay_q;
        res_o.trans_index = index_q;
      end
      PH_CM_SIZE, PH_SK_SIZE: begin
        if (byte_i == 8'd0) begin
          phase_d     = PH_LABEL;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_EXT_END;
        end else begin
          count_d = byte_i;
          phase_d = (phase_q == PH_CM_SIZE) ? PH_CM_DATA : PH_SK_DATA;
        end
      end
      PH_CM_DATA: begin
        count_d = count_dec;
        if (count_dec == 8'd0) begin
          phase_d = PH_CM_SIZE;
        end
        res_o.valid     = 1'b1;
        res_o.kind      = KIND_COMMENT;
        res_o.data_byte = byte_i;
      end
      PH_SK_DATA: begin
        count_d = count_dec;
        if (count_dec == 8'd0) begin
          phase_d = PH_SK_SIZE;
        end
      end
      PH_APP_SIZE: begin
        if (byte_i != AppSize) begin
          phase_d     = PH_LABEL;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_BAD_APP;
        end else begin
          count_d = AppIdLen;
          phase_d = PH_APP_ID;
        end
      end
      PH_APP_ID: begin
        count_d = count_dec;
        if (count_dec == 8'd0) begin
          count_d = AppAuLen;
          phase_d = PH_APP_AUTH;
        end
        res_o.valid     = 1'b1;
        res_o.kind      = KIND_APP_ID;
        res_o.data_byte = byte_i;
      end
      PH_APP_AUTH: begin
        count_d = count_dec;
        if (count_dec == 8'd0) begin
          phase_d = PH_SK_SIZE;
        end
      end
      default: begin
        phase_d = PH_LABEL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LABEL;
      count_q <= '0;
      label_q <= '0;
      flags_q <= '0;
      delay_q <= '0;
      index_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      label_q <= label_d;
      flags_q <= flags_d;
      delay_q <= delay_d;
      index_q <= index_d;
    end
  end

endmodule

FILE: rtl/core/gif_extension_block_parser.sv
// each input beat is held in the input register, and the result beat it causes in the output register
// throughput: one input beat per cycle, sustained while the output side is ready
// the output register lets a new beat in while a finished result waits to be taken
// reset (rst_ni low, asynchronous) empties both stages and returns the parser
// to awaiting a label with all stored fields cleared
module gif_extension_block_parser
  import gifx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // in_byte[7:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // data_byte[7:0], disposal[10:8], user_wait[11], transparent[12], delay[28:13],
  // trans_index[36:29], ext_label[44:37], zero[47:45]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [2:0]          m_axis_tuser    // kind[2:0]
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  gifx_res_t  out_q;
  gifx_res_t  res;
  logic       advance;
  logic       step;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  gifx_parse_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= step && res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {3'b000, out_q.ext_label, out_q.trans_index, out_q.delay,
                          out_q.transparent, out_q.user_wait, out_q.disposal,
                          out_q.data_byte};

endmodule

FILE: sim/gif_extension_block_parser_tb.sv
`timescale 1ns / 1ps

module gif_extension_block_parser_tb;
  import gifx_pkg::*;

  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PhaseBytes   = 440;
  localparam int unsigned DrainCycles  = 8;

  typedef enum logic [3:0] {
    AWAIT_LABEL,
    GC_LEN,
    GC_BODY,
    GC_TERM,
    CM_LEN,
    CM_DATA,
    APP_LEN,
    APP_ID,
    APP_AUTH,
    SKIP_LEN,
    SKIP_DATA
  } parse_phase_e;

  typedef struct packed {
    gifx_kind_e  kind;
    logic [7:0]  data_byte;
    logic [2:0]  disposal;
    logic        user_wait;
    logic        transparent;
    logic [15:0] delay;
    logic [7:0]  trans_index;
    logic [7:0]  ext_label;
  } ext_result_t;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic        typed;
    ext_result_t want;
  } dir_row_t;

  localparam int DirLen = 28;
  localparam dir_row_t DirRows [DirLen] = '{
    '{8'hF9, 1'b0, '0},
    '{8'h03, 1'b1, '{KIND_BAD_GC, 8'h00, 3'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 8'hF9}},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_BAD_APP, 8'h00, 3'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 8'hFF}},
    '{8'h21, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_EXT_END, 8'h00, 3'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 8'h21}},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_EXT_END, 8'h00, 3'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 8'h00}},
    '{8'hFE, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_EXT_END, 8'h00, 3'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 8'hFE}},
    '{8'hF9, 1'b0, '0},
    '{8'h04, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_GC_DONE, 8'h00, 3'd7, 1'b1, 1'b1, 16'hFFFF, 8'hFF, 8'hF9}},
    '{8'hF9, 1'b0, '0},
    '{8'h04, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b1, '{KIND_BAD_TERM, 8'h00, 3'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 8'hF9}},
    '{8'hFE, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_COMMENT, 8'h00, 3'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 8'hFE}},
    '{8'h00, 1'b1, '{KIND_EXT_END, 8'h00, 3'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 8'hFE}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;   // in_byte[7:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // data_byte[7:0], disposal[10:8], user_wait[11], transparent[12], delay[28:13],
  // trans_index[36:29], ext_label[44:37], zero[47:45]
  logic [OutDataW-1:0] m_axis_tdata;
  logic [2:0]          m_axis_tuser;           // kind[2:0]

  gif_extension_block_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // parser state mirrored beside the block
  parse_phase_e parse_phase = AWAIT_LABEL;
  logic [7:0]   run_left    = 8'h00;
  logic [7:0]   label_q     = 8'h00;
  logic [7:0]   flags_q     = 8'h00;
  logic [15:0]  delay_q     = 16'h0000;
  logic [7:0]   index_q     = 8'h00;

  ext_result_t  pending_results [$];
  ext_result_t  rx_want;
  int unsigned  bytes_sent   = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  tx_idle_pct  = 0;
  int unsigned  rx_idle_pct  = 0;
  logic         hold_go      = 1'b0;
  logic         rx_hold      = 1'b0;

  function automatic ext_result_t make_result(gifx_kind_e k, logic [7:0] d, bit gc);
    ext_result_t r;
    r.kind        = k;
    r.data_byte   = d;
    r.disposal    = gc ? flags_q[4:2] : 3'd0;
    r.user_wait   = gc ? flags_q[1] : 1'b0;
    r.transparent = gc ? flags_q[0] : 1'b0;
    r.delay       = gc ? delay_q : 16'h0000;
    r.trans_index = gc ? index_q : 8'h00;
    r.ext_label   = label_q;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output ext_result_t r);
    logic [7:0] pos;
    r = '0;
    case (parse_phase)
      AWAIT_LABEL: begin
        label_q = b;
        if (b == LblGc) parse_phase = GC_LEN;
        else if (b == LblComm) parse_phase = CM_LEN;
        else if (b == LblApp) parse_phase = APP_LEN;
        else parse_phase = SKIP_LEN;
        return 1'b0;
      end
      GC_LEN: begin
        if (b != GcSize) begin
          parse_phase = AWAIT_LABEL;
          r = make_result(KIND_BAD_GC, 8'h00, 1'b0);
          return 1'b1;
        end
        run_left = GcSize;
        parse_phase = GC_BODY;
        return 1'b0;
      end
      GC_BODY: begin
        pos = GcSize - run_left;
        if (pos == 8'd0) flags_q = b;
        else if (pos == 8'd1) delay_q[7:0] = b;
        else if (pos == 8'd2) delay_q[15:8] = b;
        else index_q = b;
        run_left = run_left - 8'd1;
        if (run_left == 8'd0) parse_phase = GC_TERM;
        return 1'b0;
      end
      GC_TERM: begin
        parse_phase = AWAIT_LABEL;
        r = make_result((b == 8'h00) ? KIND_GC_DONE : KIND_BAD_TERM, 8'h00, 1'b1);
        return 1'b1;
      end
      CM_LEN, SKIP_LEN: begin
        if (b == 8'h00) begin
          parse_phase = AWAIT_LABEL;
          r = make_result(KIND_EXT_END, 8'h00, 1'b0);
          return 1'b1;
        end
        run_left = b;
        parse_phase = (parse_phase == CM_LEN) ? CM_DATA : SKIP_DATA;
        return 1'b0;
      end
      CM_DATA: begin
        run_left = run_left - 8'd1;
        if (run_left == 8'd0) parse_phase = CM_LEN;
        r = make_result(KIND_COMMENT, b, 1'b0);
        return 1'b1;
      end
      SKIP_DATA: begin
        run_left = run_left - 8'd1;
        if (run_left == 8'd0) parse_phase = SKIP_LEN;
        return 1'b0;
      end
      APP_LEN: begin
        if (b != AppSize) begin
          parse_phase = AWAIT_LABEL;
          r = make_result(KIND_BAD_APP, 8'h00, 1'b0);
          return 1'b1;
        end
        run_left = AppIdLen;
        parse_phase = APP_ID;
        return 1'b0;
      end
      APP_ID: begin
        run_left = run_left - 8'd1;
        if (run_left == 8'd0) begin
          run_left = AppAuLen;
          parse_phase = APP_AUTH;
        end
        r = make_result(KIND_APP_ID, b, 1'b0);
        return 1'b1;
      end
      APP_AUTH: begin
        run_left = run_left - 8'd1;
        if (run_left == 8'd0) parse_phase = SKIP_LEN;
        return 1'b0;
      end
      default: begin
        parse_phase = AWAIT_LABEL;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, got %0h want %0h", $realtime, name, got, want);
      mismatch_cnt++;
    end
  endtask

  // receiver: random stalls plus the long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        check_field("unexpected beat", 16'd1, 16'd0);
      end else begin
        rx_want = pending_results.pop_front();
        check_field("kind", 16'(m_axis_tuser), 16'(rx_want.kind));
        check_field("data_byte", 16'(m_axis_tdata[7:0]), 16'(rx_want.data_byte));
        check_field("disposal", 16'(m_axis_tdata[10:8]), 16'(rx_want.disposal));
        check_field("user_wait", 16'(m_axis_tdata[11]), 16'(rx_want.user_wait));
        check_field("transparent", 16'(m_axis_tdata[12]), 16'(rx_want.transparent));
        check_field("delay", m_axis_tdata[28:13], rx_want.delay);
        check_field("trans_index", 16'(m_axis_tdata[36:29]),
                    16'(rx_want.trans_index));
        check_field("ext_label", 16'(m_axis_tdata[44:37]), 16'(rx_want.ext_label));
        check_field("pad", 16'(m_axis_tdata[47:45]), 16'd0);
      end
    end
    m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always begin
    @(posedge hold_go);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic typed, input ext_result_t want);
    ext_result_t predicted;
    bit          has;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    has = parse_byte(b, predicted);
    if (typed) pending_results.push_back(want);
    else if (has) pending_results.push_back(predicted);
    bytes_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  task automatic put_subblocks(input int unsigned max_blocks);
    int unsigned nblk;
    int unsigned len;
    nblk = $urandom_range(0, max_blocks);
    repeat (nblk) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 255) : $urandom_range(1, 12);
      put_byte(8'(len));
      repeat (len) put_byte(8'($urandom_range(0, 255)));
    end
    put_byte(8'h00);
  endtask

  task automatic put_extension();
    int unsigned pick;
    logic [7:0]  len;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      put_byte(LblGc);
      len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : GcSize;
      put_byte(len);
      if (len == GcSize) begin
        repeat (4) put_byte(8'($urandom_range(0, 255)));
        put_byte(($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      end
    end else if (pick < 45) begin
      put_byte(LblComm);
      put_subblocks(3);
    end else if (pick < 65) begin
      put_byte(LblApp);
      len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : AppSize;
      put_byte(len);
      if (len == AppSize) begin
        repeat (11) put_byte(8'($urandom_range(0, 255)));
        put_subblocks(2);
      end
    end else if (pick < 75) begin
      put_byte(8'h01);
      put_byte(8'd12);
      repeat (12) put_byte(8'($urandom_range(0, 255)));
      put_subblocks(2);
    end else if (pick < 88) begin
      put_byte(8'($urandom_range(0, 255)));
      put_subblocks(3);
    end else begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
    end
    // bring broken sequences back to a label boundary
    while (parse_phase != AWAIT_LABEL)
      put_byte((parse_phase inside {GC_LEN, CM_LEN, APP_LEN, SKIP_LEN}) ?
               8'h00 : 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned start;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 31;
    rx_idle_pct = 60;
    for (int i = 0; i < DirLen; i++)
      send_byte(DirRows[i].in_byte, DirRows[i].typed, DirRows[i].want);

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 31 : (p == 1) ? 60 : 0;
      rx_idle_pct = (p == 0) ? 60 : (p == 1) ? 31 : 0;
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) put_extension();
      wait_drained();
      repeat (DrainCycles) @(posedge clk_i);
    end

    // long receiver hold-off while a comment keeps the input busy
    hold_go <= 1'b1;
    put_byte(LblComm);
    put_byte(8'd60);
    repeat (60) put_byte(8'($urandom_range(0, 255)));
    put_byte(8'h00);
    wait_drained();
    hold_go <= 1'b0;

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("gif_extension_block_parser_tb: clean");
    end else begin
      $display("gif_extension_block_parser_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("gif_extension_block_parser_tb: errors");
    $finish;
  end

endmodule
